[rtl/opt_pkg.sv]
// Package with the shared types and codes of the ordered process table.
`timescale 1ns / 1ps
package opt_pkg;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_APPEND = 3'd1,
        OP_INSERT = 3'd2,
        OP_DELETE = 3'd3,
        OP_FIND   = 3'd4,
        OP_SETPRI = 3'd5,
        OP_SORT   = 3'd6,
        OP_NOP    = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        KIND_LIST    = 3'd0,
        KIND_FOUND   = 3'd1,
        KIND_MISSING = 3'd2,
        KIND_FULL    = 3'd3,
        KIND_EMPTY   = 3'd4
    } t_kind;

    // One table entry as it is stored in the memory.
    typedef struct packed {
        logic [15:0]        id;
        logic [7:0]         strategy;
        logic signed [15:0] prio;
    } t_entry;

    typedef struct packed {
        t_op                op;
        logic [15:0]        key_id;
        logic [15:0]        new_id;
        logic [7:0]         new_strategy;
        logic signed [15:0] new_priority;
    } t_cmd;

    typedef struct packed {
        t_kind              kind;
        logic [15:0]        entry_id;
        logic signed [15:0] entry_priority;
        logic               last;
    } t_result;

endpackage

[rtl/opt_if.sv]
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps
interface opt_cmd_if;
    logic            valid;
    logic            ready;
    opt_pkg::t_cmd   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface opt_res_if;
    logic             valid;
    logic             ready;
    opt_pkg::t_result payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/ordered_process_table.sv]
// Top level of the ordered process table: a sequencer around one entry memory.
// Sequence: a command is decoded in the cycle after it is accepted, where load and the
// full or empty statuses end; a lookup then checks each entry in turn, insert and delete
// write back each moved entry (insert then places the new entry), the sort holds each
// outer entry and compares it with the neighbors it reads; a listing sends each entry.
// Throughput: one command at a time, i_cmd.ready is high only while idle; a waiting
// result stalls the listing. Reset clears the sequencer, the count and the result valid.
`timescale 1ns / 1ps
module ordered_process_table #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    opt_cmd_if.sink   i_cmd,
    opt_res_if.source o_res
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_FIND_RD, S_FIND_CHK, S_SHIFT_RD, S_SHIFT_WR, S_INS_PUT,
        S_SORT_RD_I, S_SORT_HOLD, S_SORT_RD_J, S_SORT_CMP, S_SORT_PUT, S_LIST_RD,
        S_LIST_OUT, S_OUT
    } t_state;

    // The table lives in one memory with a registered read port and one write port.
    opt_pkg::t_entry mem [TABLE_DEPTH];
    opt_pkg::t_entry r_rdata;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    opt_pkg::t_entry wr_data;
    opt_pkg::t_entry new_entry;

    t_state           r_state;
    opt_pkg::t_cmd    r_cmd;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_pos;     // position of the key entry of an insert
    logic [CW-1:0]    r_i;       // general walk index
    logic [CW-1:0]    r_j;       // inner index of the sort
    opt_pkg::t_entry  r_hold;    // entry being placed by the sort
    logic             r_res_valid;
    opt_pkg::t_result r_res;

    assign i_cmd.ready   = (r_state == S_IDLE);
    assign o_res.valid   = r_res_valid;
    assign o_res.payload = r_res;

    assign new_entry = '{id: r_cmd.new_id, strategy: r_cmd.new_strategy,
                         prio: r_cmd.new_priority};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    // Read address and write port are decoded from the state. Every write lands before
    // any read of the same entry, so no forwarding is needed.
    always_comb begin
        rd_addr = r_i[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_i[AW-1:0];
        wr_data = r_rdata;
        unique case (r_state)
            S_DISPATCH: begin
                // Load and append put the new entry at the tail when there is room.
                if ((r_cmd.op == opt_pkg::OP_LOAD || r_cmd.op == opt_pkg::OP_APPEND) &&
                    r_count < CW'(TABLE_DEPTH)) begin
                    wr_en   = 1'b1;
                    wr_addr = r_count[AW-1:0];
                    wr_data = new_entry;
                end
            end
            S_FIND_CHK: begin
                // Set priority rewrites the matching entry in place.
                if (r_cmd.op == opt_pkg::OP_SETPRI && r_rdata.id == r_cmd.key_id) begin
                    wr_en        = 1'b1;
                    wr_data.prio = r_cmd.new_priority;
                end
            end
            S_SHIFT_RD: rd_addr = (r_cmd.op == opt_pkg::OP_DELETE) ?
                                  AW'(r_i + CW'(1)) : AW'(r_i - CW'(1));
            S_SHIFT_WR: wr_en = 1'b1;
            S_INS_PUT: begin
                wr_en   = 1'b1;
                wr_addr = AW'(r_pos + CW'(1));
                wr_data = new_entry;
            end
            S_SORT_RD_J: rd_addr = AW'(r_j - CW'(1));
            S_SORT_CMP: begin
                // A larger neighbor moves up one slot.
                wr_en   = ($signed(r_rdata.prio) > $signed(r_hold.prio));
                wr_addr = r_j[AW-1:0];
            end
            S_SORT_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_j[AW-1:0];
                wr_data = r_hold;
            end
            default: ;
        endcase
    end

    function automatic opt_pkg::t_result mk_result(opt_pkg::t_kind k, logic [15:0] id,
                                                   logic signed [15:0] p, logic lst);
        opt_pkg::t_result r;
        r.kind = k;
        r.entry_id = id;
        r.entry_priority = p;
        r.last = lst;
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cmd   <= i_cmd.payload;
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    case (r_cmd.op) inside
                        opt_pkg::OP_LOAD, opt_pkg::OP_APPEND: begin
                            if (r_count >= CW'(TABLE_DEPTH)) begin
                                r_res       <= mk_result(opt_pkg::KIND_FULL, r_cmd.new_id,
                                                         16'sd0, 1'b1);
                                r_res_valid <= 1'b1;
                                r_state     <= S_OUT;
                            end else begin
                                r_count <= r_count + CW'(1);
                                r_i     <= '0;
                                r_state <= (r_cmd.op == opt_pkg::OP_APPEND) ? S_LIST_RD
                                                                            : S_IDLE;
                            end
                        end
                        opt_pkg::OP_NOP: r_state <= S_IDLE;
                        default: begin
                            if (r_count == '0) begin
                                r_res       <= mk_result(opt_pkg::KIND_EMPTY, 16'd0,
                                                         16'sd0, 1'b1);
                                r_res_valid <= 1'b1;
                                r_state     <= S_OUT;
                            end else if (r_cmd.op == opt_pkg::OP_SORT) begin
                                // A single entry is already sorted and is just listed.
                                if (r_count > CW'(1)) begin
                                    r_i     <= CW'(1);
                                    r_state <= S_SORT_RD_I;
                                end else begin
                                    r_i     <= '0;
                                    r_state <= S_LIST_RD;
                                end
                            end else begin
                                r_i     <= '0;
                                r_state <= S_FIND_RD;
                            end
                        end
                    endcase
                end
                S_FIND_RD: r_state <= S_FIND_CHK;
                S_FIND_CHK: begin
                    if (r_rdata.id == r_cmd.key_id) begin
                        case (r_cmd.op)
                            opt_pkg::OP_FIND: begin
                                r_res       <= mk_result(opt_pkg::KIND_FOUND, r_rdata.id,
                                                         r_rdata.prio, 1'b1);
                                r_res_valid <= 1'b1;
                                r_state     <= S_OUT;
                            end
                            opt_pkg::OP_SETPRI: begin
                                r_res       <= mk_result(opt_pkg::KIND_FOUND, r_rdata.id,
                                                         r_cmd.new_priority, 1'b1);
                                r_res_valid <= 1'b1;
                                r_state     <= S_OUT;
                            end
                            opt_pkg::OP_INSERT: begin
                                if (r_count >= CW'(TABLE_DEPTH)) begin
                                    r_res       <= mk_result(opt_pkg::KIND_FULL,
                                                             r_cmd.new_id, 16'sd0, 1'b1);
                                    r_res_valid <= 1'b1;
                                    r_state     <= S_OUT;
                                end else begin
                                    // Shift the tail up from the end, then place the entry.
                                    r_pos   <= r_i;
                                    r_i     <= r_count;
                                    r_state <= (r_count > r_i + CW'(1)) ? S_SHIFT_RD
                                                                        : S_INS_PUT;
                                end
                            end
                            default: begin // delete: pull the tail down over the entry
                                if (r_i + CW'(1) < r_count) begin
                                    r_state <= S_SHIFT_RD;
                                end else begin
                                    r_count <= r_count - CW'(1);
                                    r_i     <= '0;
                                    r_state <= S_LIST_RD;
                                end
                            end
                        endcase
                    end else if (r_i + CW'(1) >= r_count) begin
                        r_res       <= mk_result(opt_pkg::KIND_MISSING, r_cmd.key_id,
                                                 16'sd0, 1'b1);
                        r_res_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_FIND_RD;
                    end
                end
                S_SHIFT_RD: r_state <= S_SHIFT_WR;
                S_SHIFT_WR: begin
                    // The neighbor just read is written at r_i in this cycle.
                    if (r_cmd.op == opt_pkg::OP_DELETE) begin
                        if (r_i + CW'(2) < r_count) begin
                            r_i     <= r_i + CW'(1);
                            r_state <= S_SHIFT_RD;
                        end else begin
                            r_count <= r_count - CW'(1);
                            r_i     <= '0;
                            r_state <= S_LIST_RD;
                        end
                    end else if (r_i - CW'(1) > r_pos + CW'(1)) begin
                        r_i     <= r_i - CW'(1);
                        r_state <= S_SHIFT_RD;
                    end else begin
                        r_state <= S_INS_PUT;
                    end
                end
                S_INS_PUT: begin
                    r_count <= r_count + CW'(1);
                    r_i     <= '0;
                    r_state <= S_LIST_RD;
                end
                S_SORT_RD_I: r_state <= S_SORT_HOLD;
                S_SORT_HOLD: begin
                    r_hold  <= r_rdata;
                    r_j     <= r_i;
                    r_state <= S_SORT_RD_J;
                end
                S_SORT_RD_J: r_state <= S_SORT_CMP;
                S_SORT_CMP: begin
                    // Strict compare, so equal priorities keep their order.
                    if ($signed(r_rdata.prio) > $signed(r_hold.prio)) begin
                        r_j     <= r_j - CW'(1);
                        r_state <= (r_j > CW'(1)) ? S_SORT_RD_J : S_SORT_PUT;
                    end else begin
                        r_state <= S_SORT_PUT;
                    end
                end
                S_SORT_PUT: begin
                    if (r_i + CW'(1) < r_count) begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_SORT_RD_I;
                    end else begin
                        r_i     <= '0;
                        r_state <= S_LIST_RD;
                    end
                end
                S_LIST_RD: begin
                    if (r_count == '0) begin
                        // Deleting the only entry leaves nothing to list.
                        r_res       <= mk_result(opt_pkg::KIND_EMPTY, 16'd0, 16'sd0, 1'b1);
                        r_res_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end else begin
                        if (r_res_valid && o_res.ready) begin
                            r_res_valid <= 1'b0;
                        end
                        r_state <= S_LIST_OUT;
                    end
                end
                S_LIST_OUT: begin
                    if (!r_res_valid || o_res.ready) begin
                        r_res       <= mk_result(opt_pkg::KIND_LIST, r_rdata.id, r_rdata.prio,
                                                 r_i + CW'(1) == r_count);
                        r_res_valid <= 1'b1;
                        if (r_i + CW'(1) == r_count) begin
                            r_state <= S_OUT;
                        end else begin
                            r_i     <= r_i + CW'(1);
                            r_state <= S_LIST_RD;
                        end
                    end
                end
                S_OUT: begin
                    // Wait until the final result of this command is taken.
                    if (!r_res_valid || o_res.ready) begin
                        r_res_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Never more entries than the table holds.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH)) else $error("entry count overflow");
    // Commands are only taken when no result is pending.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |-> !r_res_valid) else $error("accept with result pending");
    // A list entry never reports past the count.
    a_list_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST_OUT) |-> (r_i < r_count)) else $error("list index past count");
    // A waiting result stays put until it is taken.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> (o_res.valid && $stable(o_res.payload)))
        else $error("result changed while waiting");
endmodule
